@@ rtl/ptts_pkg.sv @@
// Shared types and constants for the periodic task tick scheduler.
package ptts_pkg;

	// Default table size and configuration reset value.
	localparam int unsigned MAX_TASKS_DEF = 8;
	localparam logic [7:0] OVF_PER_TICK_RST = 8'd1;

	// Operation codes carried in the input word.
	typedef enum logic [1:0] {
		OP_OVERFLOW = 2'd0,
		OP_INSTALL  = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_SET_RUN  = 2'd3
	} op_t;

	// Input word.
	typedef struct packed {
		op_t         operation;
		logic [2:0]  slot;
		logic [15:0] period;
		logic [15:0] first_delay;
		logic        run_flag;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic [7:0] due_mask;
		logic       pass_done;
	} out_word_t;

	// One entry of the slot memory.
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] countdown;
	} slot_entry_t;

endpackage

@@ rtl/ptts_ram.sv @@
// Slot memory: one write port and one read port with registered read data.
module ptts_ram #(
	parameter int unsigned DEPTH = ptts_pkg::MAX_TASKS_DEF,
	parameter int unsigned AW = 3
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  ptts_pkg::slot_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output ptts_pkg::slot_entry_t rd_data
);

	ptts_pkg::slot_entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/ptts_sched.sv @@
// Scheduler control: prescaler, slot flags and the read-modify-write pass over the slot memory.
module ptts_sched #(
	parameter int unsigned MAX_TASKS = ptts_pkg::MAX_TASKS_DEF,
	parameter int unsigned AW = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  ptts_pkg::in_word_t    in_data,
	input  logic [7:0]            ovf_per_tick,
	input  logic                  buf_full,
	output logic                  res_push,
	output ptts_pkg::out_word_t   res_data,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output ptts_pkg::slot_entry_t wr_data,
	output logic                  rd_en,
	output logic [AW-1:0]         rd_addr,
	input  ptts_pkg::slot_entry_t rd_data
);

	typedef enum logic {
		S_IDLE,
		S_PASS
	} state_t;

	state_t                 state_q;
	logic [7:0]             ovf_cnt_q;
	logic [MAX_TASKS-1:0]   present_q;
	logic [MAX_TASKS-1:0]   running_q;
	logic [AW-1:0]          idx_s1;
	logic [7:0]             due_q;

	logic                   accept;
	logic                   is_ovf;
	logic [7:0]             cnt_inc;
	logic                   hit;
	logic                   slot_ok;
	logic [AW-1:0]          slot_idx;
	logic                   last;
	logic                   active_s1;
	logic                   zero_s1;
	logic [15:0]            new_cd;
	logic [7:0]             due_bit;
	logic [7:0]             due_next;

	// Decode of the incoming word.
	assign in_ready = (state_q == S_IDLE) && !buf_full;
	assign accept   = in_valid && in_ready;
	assign is_ovf   = (in_data.operation == ptts_pkg::OP_OVERFLOW);
	assign cnt_inc  = ovf_cnt_q + 8'd1;
	assign hit      = (cnt_inc == ovf_per_tick);
	assign slot_ok  = (32'(in_data.slot) < 32'(MAX_TASKS));
	assign slot_idx = AW'(in_data.slot);

	// Per-slot update for the entry whose read data arrives this cycle.
	assign last      = (idx_s1 == AW'(MAX_TASKS - 1));
	assign active_s1 = present_q[idx_s1] && running_q[idx_s1];
	assign zero_s1   = (rd_data.countdown == 16'd0);
	assign new_cd    = zero_s1 ? (rd_data.period - 16'd1) : (rd_data.countdown - 16'd1);
	assign due_bit   = (active_s1 && zero_s1 && (32'(idx_s1) < 32'd8)) ?
		(8'd1 << 3'(idx_s1)) : 8'd0;
	assign due_next  = due_q | due_bit;

	// Memory accesses and result push. The pass writes slot i while reading
	// slot i+1, and no other word enters during a pass, so accesses never collide.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = slot_idx;
		wr_data  = '{period: in_data.period, countdown: in_data.first_delay};
		res_push = 1'b0;
		res_data = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_ovf) begin
						if (hit) begin
							rd_en = 1'b1;
						end else begin
							res_push = 1'b1;
						end
					end else begin
						res_push = 1'b1;
						wr_en = slot_ok && (in_data.operation == ptts_pkg::OP_INSTALL);
					end
				end
			end
			S_PASS: begin
				if (active_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1;
					wr_data = '{period: rd_data.period, countdown: new_cd};
				end
				if (last) begin
					res_push           = 1'b1;
					res_data.due_mask  = due_next;
					res_data.pass_done = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_s1 + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// State, prescaler, flags and pass registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ovf_cnt_q <= '0;
			present_q <= '0;
			running_q <= '0;
			idx_s1    <= '0;
			due_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_ovf) begin
							ovf_cnt_q <= hit ? 8'd0 : cnt_inc;
							if (hit) begin
								state_q <= S_PASS;
								idx_s1  <= '0;
								due_q   <= '0;
							end
						end else if (slot_ok) begin
							case (in_data.operation)
								ptts_pkg::OP_INSTALL: begin
									present_q[slot_idx] <= 1'b1;
									running_q[slot_idx] <= in_data.run_flag;
								end
								ptts_pkg::OP_REMOVE: begin
									present_q[slot_idx] <= 1'b0;
								end
								ptts_pkg::OP_SET_RUN: begin
									running_q[slot_idx] <= in_data.run_flag;
								end
								default: begin
								end
							endcase
						end
					end
				end
				S_PASS: begin
					due_q <= due_next;
					if (last) begin
						state_q <= S_IDLE;
					end else begin
						idx_s1 <= idx_s1 + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// No word is taken while a pass walks the memory.
	a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PASS) |-> !in_ready)
		else $error("word accepted during a scheduling pass");

	// Every word other than a pass-starting overflow yields its result at once.
	a_immediate_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(is_ovf && hit)) |-> res_push)
		else $error("missing immediate result");

	// A pass result comes only from the last slot of a pass.
	a_pass_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.pass_done) |-> (state_q == S_PASS && last))
		else $error("pass result outside the end of a pass");

	// The write-back never targets the entry being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same slot entry");

endmodule

@@ rtl/ptts_outbuf.sv @@
// Two-entry result buffer: output register plus a skid entry.
module ptts_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptts_pkg::out_word_t push_data,
	output logic                full,
	output logic                out_valid,
	input  logic                out_ready,
	output ptts_pkg::out_word_t out_data
);

	logic                head_v_q;
	logic                skid_v_q;
	ptts_pkg::out_word_t head_q;
	ptts_pkg::out_word_t skid_q;
	logic                pop;

	assign pop       = head_v_q && out_ready;
	assign full      = skid_v_q;
	assign out_valid = head_v_q;
	assign out_data  = head_q;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					head_v_q <= 1'b0;
				end
			end
			if (push) begin
				if (!head_v_q || (pop && !skid_v_q)) begin
					head_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end
		end
	end

	// Payload moves: the skid entry drains into the head on a pop.
	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			head_q <= skid_q;
		end
		if (push) begin
			if (!head_v_q || (pop && !skid_v_q)) begin
				head_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

@@ rtl/periodic_task_tick_scheduler_top.sv @@
// Top level of the periodic task tick scheduler.
//
//  channel | direction | word          | handshake
//  in      | input     | in_data       | in_valid / in_ready
//  out     | output    | out_data      | out_valid / out_ready
//  cfg     | input     | cfg_data (8b) | cfg_valid / cfg_ready
//
// Install, remove, set-running and overflows short of a tick push their result when accepted.
// An overflow that completes a tick starts a pass over every slot: the pass reads and
// writes back one slot entry per cycle through the single read port of the slot memory.
// Reset clears the prescaler, the present and running flags and the result buffer;
// the period and countdown memory is not cleared and needs no clearing pass.
// A two-entry result buffer lets one further word enter while a result waits on out_ready.
module periodic_task_tick_scheduler_top #(
	parameter int unsigned MAX_TASKS = ptts_pkg::MAX_TASKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptts_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ptts_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	logic [7:0]            ovf_per_tick_q;
	logic                  buf_full;
	logic                  res_push;
	ptts_pkg::out_word_t   res_data;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	ptts_pkg::slot_entry_t wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	ptts_pkg::slot_entry_t rd_data;

	// Configuration register: overflows per scheduler tick.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_per_tick_q <= ptts_pkg::OVF_PER_TICK_RST;
		end else if (cfg_valid) begin
			ovf_per_tick_q <= cfg_data;
		end
	end

	// Slot memory holding period and countdown.
	ptts_ram #(
		.DEPTH(MAX_TASKS),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Scheduler control.
	ptts_sched #(
		.MAX_TASKS(MAX_TASKS),
		.AW(AW)
	) u_sched (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.ovf_per_tick(ovf_per_tick_q),
		.buf_full(buf_full),
		.res_push(res_push),
		.res_data(res_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Result buffer.
	ptts_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.push_data(res_data),
		.full(buf_full),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

@@ sim/periodic_task_tick_scheduler_top_test.sv @@
// Self-checking testbench for the periodic task tick scheduler top level.
module periodic_task_tick_scheduler_top_test;
	import ptts_pkg::*;

	localparam int unsigned TABLE_SIZE = MAX_TASKS_DEF;
	// A completing overflow walks the whole table; leave some margin past that.
	localparam int SETTLE_CYCLES = TABLE_SIZE + 4;
	localparam int LONG_HOLD = 300;
	localparam int RX_MODE_SPAN = 150;

	// Receiver back-pressure patterns, cycled over time.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_word_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	periodic_task_tick_scheduler_top #(
		.MAX_TASKS(TABLE_SIZE)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Clock with a period of 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Local copy of the scheduler state.
	logic [7:0]  tick_divider = OVF_PER_TICK_RST;
	logic [7:0]  prescale = '0;
	bit          slot_present [TABLE_SIZE] = '{default: 1'b0};
	bit          slot_running [TABLE_SIZE] = '{default: 1'b0};
	logic [15:0] slot_period [TABLE_SIZE];
	logic [15:0] slot_countdown [TABLE_SIZE];

	in_word_t  command_backlog [$];
	out_word_t due_forecast [$];
	out_word_t forecast_head;

	bit       in_fire = 1'b0;
	bit       long_stall_req = 1'b0;
	int       burst_left = 8;
	int       gap_left = 0;
	int       hold_left = 0;
	int       rx_cycle = 0;
	rx_mode_t rx_mode = RX_OPEN;

	int mismatch_count = 0;
	int words_taken = 0;
	int results_seen = 0;
	int passes_checked = 0;
	int due_hits = 0;
	int cfg_writes = 0;

	// Apply one input word to the local state and return the result word it should give.
	function automatic out_word_t advance_schedule(input in_word_t w);
		out_word_t res;
		res = '0;
		if (w.operation == OP_OVERFLOW) begin
			prescale = prescale + 8'd1;
			if (prescale == tick_divider) begin
				prescale = '0;
				res.pass_done = 1'b1;
				for (int i = 0; i < TABLE_SIZE; i++) begin
					if (slot_present[i] && slot_running[i]) begin
						if (slot_countdown[i] == 16'd0) begin
							res.due_mask[i] = 1'b1;
							slot_countdown[i] = slot_period[i] - 16'd1;
						end else begin
							slot_countdown[i] = slot_countdown[i] - 16'd1;
						end
					end
				end
			end
		end else if (w.slot < TABLE_SIZE) begin
			case (w.operation)
				OP_INSTALL: begin
					slot_present[w.slot] = 1'b1;
					slot_running[w.slot] = w.run_flag;
					slot_period[w.slot] = w.period;
					slot_countdown[w.slot] = w.first_delay;
				end
				OP_REMOVE: begin
					slot_present[w.slot] = 1'b0;
				end
				default: begin
					slot_running[w.slot] = w.run_flag;
				end
			endcase
		end
		return res;
	endfunction

	// Random word: mostly small periods and delays so that tasks fire often.
	function automatic in_word_t random_word(input int ovf_pct);
		in_word_t w;
		w.slot = 3'($urandom_range(0, TABLE_SIZE - 1));
		w.period = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		w.first_delay = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 6));
		w.run_flag = ($urandom_range(0, 5) != 0);
		if ($urandom_range(0, 99) < ovf_pct) begin
			w.operation = OP_OVERFLOW;
		end else begin
			case ($urandom_range(0, 2))
				0: w.operation = OP_INSTALL;
				1: w.operation = OP_REMOVE;
				default: w.operation = OP_SET_RUN;
			endcase
		end
		return w;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("MISMATCH at %0t, result %0d, %s: got %0h, want %0h",
			$time, results_seen, field, got, want);
		mismatch_count++;
	endtask

	task automatic push_word(input op_t op, input int slot, input int period,
			input int first, input bit run);
		in_word_t w;
		w.operation = op;
		w.slot = 3'(slot);
		w.period = 16'(period);
		w.first_delay = 16'(first);
		w.run_flag = run;
		command_backlog.push_back(w);
	endtask

	task automatic queue_random_words(input int count, input int ovf_pct);
		@(posedge clk);
		repeat (count) command_backlog.push_back(random_word(ovf_pct));
	endtask

	// Wait until every queued word is sent and its result has come back, then settle.
	// The check runs at the rising edge, where the driven valid is already stable.
	task automatic wait_all_results;
		while (command_backlog.size() != 0 || in_valid || due_forecast.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_tick_divider(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tick_divider = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// Word still waiting for acceptance; hold it.
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (command_backlog.size() == 0) begin
			in_valid <= 1'b0;
		end else begin
			in_data <= command_backlog.pop_front();
			in_valid <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end
	end

	// Receiver: a rotating stall pattern, plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_stall_req) begin
			long_stall_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		rx_cycle++;
		rx_mode = rx_mode_t'((rx_cycle / RX_MODE_SPAN) % 4);
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
				default: out_ready <= rx_cycle[1];
			endcase
		end
	end

	// Monitor: predict on each accepted input word, check each accepted result word.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire = 1'b0;
		end else begin
			in_fire = in_valid && in_ready;
			if (in_fire) begin
				due_forecast.push_back(advance_schedule(in_data));
				words_taken++;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (due_forecast.size() == 0) begin
					report_mismatch("unexpected result word", int'(out_data), 0);
				end else begin
					forecast_head = due_forecast.pop_front();
					if (out_data.due_mask !== forecast_head.due_mask)
						report_mismatch("due_mask", int'(out_data.due_mask),
							int'(forecast_head.due_mask));
					if (out_data.pass_done !== forecast_head.pass_done)
						report_mismatch("pass_done", int'(out_data.pass_done),
							int'(forecast_head.pass_done));
					if (forecast_head.pass_done)
						passes_checked++;
					if (forecast_head.due_mask != 8'd0)
						due_hits++;
				end
			end
		end
	end

	// Run limit.
	initial begin
		#4000000;
		$display("timeout with %0d result words outstanding", due_forecast.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus sequence.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words with the reset divider of one: every overflow is a pass.
		// All slots are installed first so that no pass sees an unwritten entry.
		@(posedge clk);
		push_word(OP_INSTALL, 0, 0, 0, 1'b1);           // zero period reloads to all ones
		push_word(OP_INSTALL, 1, 1, 0, 1'b1);
		push_word(OP_INSTALL, 2, 3, 2, 1'b1);
		push_word(OP_INSTALL, 3, 16'hFFFF, 16'hFFFF, 1'b1);
		push_word(OP_INSTALL, 4, 2, 1, 1'b0);           // installed but stopped
		push_word(OP_INSTALL, 5, 5, 0, 1'b1);
		push_word(OP_INSTALL, 6, 16'h8000, 16'h0001, 1'b1);
		push_word(OP_INSTALL, 7, 2, 0, 1'b1);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		push_word(OP_OVERFLOW, 7, 16'hFFFF, 16'hFFFF, 1'b1);
		push_word(OP_OVERFLOW, 3, 0, 0, 1'b0);
		push_word(OP_SET_RUN, 4, 0, 0, 1'b1);
		push_word(OP_REMOVE, 5, 0, 0, 1'b0);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		// Running flag set on an absent slot is stored, then install overwrites it.
		push_word(OP_SET_RUN, 5, 0, 0, 1'b0);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		push_word(OP_INSTALL, 5, 4, 0, 1'b1);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		push_word(OP_SET_RUN, 2, 0, 0, 1'b0);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		push_word(OP_REMOVE, 7, 0, 0, 1'b0);
		// Removed slot keeps its fields; a plain set-running must not bring it back.
		push_word(OP_SET_RUN, 7, 0, 0, 1'b1);
		push_word(OP_OVERFLOW, 0, 0, 0, 1'b0);
		wait_all_results;

		write_tick_divider(8'd1);
		queue_random_words(150, 60);
		wait_all_results;

		// Results held off for a long stretch while words keep coming.
		write_tick_divider(8'd2);
		queue_random_words(110, 55);
		long_stall_req = 1'b1;
		wait_all_results;

		write_tick_divider(8'd7);
		queue_random_words(100, 65);
		wait_all_results;

		// Raise the divider, let the prescaler climb, then lower it below the count.
		write_tick_divider(8'd200);
		queue_random_words(60, 100);
		wait_all_results;
		write_tick_divider(8'd3);
		queue_random_words(220, 95);
		wait_all_results;

		// A divider of zero means a pass once every 256 overflows.
		write_tick_divider(8'd0);
		queue_random_words(270, 96);
		wait_all_results;

		write_tick_divider(8'd255);
		queue_random_words(265, 96);
		wait_all_results;

		$display("covered %0d input words and %0d result words over %0d divider settings",
			words_taken, results_seen, cfg_writes + 1);
		$display("checked %0d scheduling passes, %0d of them with tasks due",
			passes_checked, due_hits);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
